@@ design/kmds_pkg.sv @@
// ----------------------------------------------------------------------------
// kmds_pkg: shared definitions for the key matrix debounce scanner
// Holds defaults, message codes, register indexes and the lane event type.
// ----------------------------------------------------------------------------
`default_nettype none

package kmds_pkg;

   // Default matrix geometry.
   localparam int DEFAULT_COLUMN_COUNT = 8;
   localparam int DEFAULT_ROW_COUNT    = 8;

   // Rows carried by one input item.
   localparam int ROW_FIELD_WIDTH = 8;
   localparam int ROW_IDX_W       = 3;

   // Debounce counter width, signed.
   localparam int CTR_W = 8;

   // Reset values of the configuration registers.
   localparam logic [6:0] DEBOUNCE_RESET = 7'd63;
   localparam logic [6:0] NOTE_BASE_RESET = 7'd36;
   localparam logic [3:0] CHANNEL_RESET   = 4'd1;
   localparam logic [6:0] VELOCITY_RESET  = 7'h7F;

   // Message status codes.
   localparam logic [7:0] NOTE_OFF_CODE = 8'h80;
   localparam logic [7:0] NOTE_ON_CODE  = 8'h90;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_DEBOUNCE_COUNT = 2'd0,
      CSR_NOTE_BASE      = 2'd1,
      CSR_MIDI_CHANNEL   = 2'd2,
      CSR_NOTE_VELOCITY  = 2'd3
   } csr_index_type;

   // What one lane found for the scanned key of its row.
   typedef struct packed {
      logic hit;    // key changed level, a message is due
      logic is_on;  // 1 for a press (note-on), 0 for a release (note-off)
   } kmds_event_type;

endpackage

`default_nettype wire

@@ design/key_matrix_debounce_scanner_core.sv @@
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_core: key matrix scanner with note messages
// Debounces every key of a scanned matrix and emits note-on and note-off.
// ----------------------------------------------------------------------------
// Each input item is one scanned column: its index and the levels of up to
// eight row lines (0 pressed, 1 released). One lane per row holds that row's
// signed debounce counters; all lanes update the scanned column in the cycle
// the item is accepted. A stable key that changes level reloads its counter
// with plus or minus debounce_count (zero acts as one) and raises a message;
// a counting key steps toward its stable value and ignores its line. The
// merge stage then sends the messages lowest row first, one per cycle while
// rsp_stall allows, with last_message set on the final one of the column.
// An item that raises messages holds req_stall high until the last of them
// has moved into the serializer's single output register; one that raises
// none never holds req_stall. A new column can be taken while the last
// message still waits on rsp_stall. Columns at or above COLUMN_COUNT are
// ignored. Configuration is written through the csr_ port, which is always
// ready, and must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_scanner_core
   import kmds_pkg::*;
#(
   parameter int COLUMN_COUNT = DEFAULT_COLUMN_COUNT,
   parameter int ROW_COUNT    = DEFAULT_ROW_COUNT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Column scan items.
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_scan_column,
   input  wire logic [7:0] req_row_levels,
   // Note messages.
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_status_byte,
   output logic [6:0]      rsp_note_number,
   output logic [6:0]      rsp_velocity_out,
   output logic            rsp_last_message,
   // Configuration writes.
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_data
);

   // Only rows that the input item carries are scanned.
   localparam int LANE_COUNT =
      (ROW_COUNT < ROW_FIELD_WIDTH) ? ROW_COUNT : ROW_FIELD_WIDTH;
   localparam int COL_IDX_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

   // Configuration registers.
   logic [6:0] debounce_ff;
   logic [6:0] note_base_ff;
   logic [3:0] channel_ff;
   logic [6:0] velocity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RESET;
         note_base_ff <= NOTE_BASE_RESET;
         channel_ff   <= CHANNEL_RESET;
         velocity_ff  <= VELOCITY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_COUNT: debounce_ff  <= csr_data;
            CSR_NOTE_BASE:      note_base_ff <= csr_data;
            CSR_MIDI_CHANNEL:   channel_ff   <= csr_data[3:0];
            CSR_NOTE_VELOCITY:  velocity_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Item acceptance and column decode.
   logic                 busy;
   logic                 item_accept;
   logic                 col_in_range;
   logic                 scan_accept;
   logic [4:0]           col_wide;
   logic [COL_IDX_W-1:0] col_index;
   logic [6:0]           load_value;

   assign req_stall    = busy;
   assign item_accept  = req_valid && !req_stall;
   assign col_wide     = {2'b0, req_scan_column};
   assign col_in_range = (32'(col_wide) < COLUMN_COUNT);
   assign scan_accept  = item_accept && col_in_range;
   assign col_index    = col_wide[COL_IDX_W-1:0];
   assign load_value   = (debounce_ff == 7'd0) ? 7'd1 : debounce_ff;

   // One lane per scanned row.
   kmds_event_type lane_event [LANE_COUNT];

   for (genvar r = 0; r < LANE_COUNT; r++) begin : g_lane
      kmds_lane #(
         .COLUMN_COUNT(COLUMN_COUNT)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .scan_accept(scan_accept),
         .col_index  (col_index),
         .row_level  (req_row_levels[r]),
         .load_value (load_value),
         .lane_event (lane_event[r])
      );
   end

   // Message serializer.
   kmds_merge #(
      .COLUMN_COUNT(COLUMN_COUNT),
      .LANE_COUNT  (LANE_COUNT)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .scan_accept     (scan_accept),
      .scan_column     (req_scan_column),
      .lane_event      (lane_event),
      .note_base       (note_base_ff),
      .midi_channel    (channel_ff),
      .note_velocity   (velocity_ff),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status_byte (rsp_status_byte),
      .rsp_note_number (rsp_note_number),
      .rsp_velocity_out(rsp_velocity_out),
      .rsp_last_message(rsp_last_message)
   );

endmodule

`default_nettype wire

@@ design/kmds_lane.sv @@
// ----------------------------------------------------------------------------
// kmds_lane: debounce counters of one matrix row
// Updates the counter of the scanned key and reports a level change.
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_lane
   import kmds_pkg::*;
#(
   parameter int COLUMN_COUNT = DEFAULT_COLUMN_COUNT,
   localparam int COL_IDX_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 scan_accept,
   input  wire logic [COL_IDX_W-1:0] col_index,
   input  wire logic                 row_level,
   input  wire logic [6:0]           load_value,
   output kmds_event_type            lane_event
);

   logic signed [CTR_W-1:0] ctr_ff [COLUMN_COUNT];
   logic signed [CTR_W-1:0] ctr_in;
   logic signed [CTR_W-1:0] old_value;
   logic signed [CTR_W-1:0] load_pos;
   kmds_event_type          found;

   assign load_pos  = signed'({1'b0, load_value});
   assign old_value = ctr_ff[col_index];

   always_comb begin
      ctr_in      = old_value;
      found.hit   = 1'b0;
      found.is_on = 1'b0;
      if (old_value < 0) begin
         ctr_in = old_value + 8'sd1;
      end else if (old_value > 8'sd1) begin
         ctr_in = old_value - 8'sd1;
      end else if (old_value == 8'sd0 && row_level) begin
         ctr_in    = load_pos;
         found.hit = 1'b1;
      end else if (old_value == 8'sd1 && !row_level) begin
         ctr_in      = -load_pos;
         found.hit   = 1'b1;
         found.is_on = 1'b1;
      end
   end

   assign lane_event = {scan_accept & found.hit, found.is_on};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COLUMN_COUNT; c++) begin
            ctr_ff[c] <= '0;
         end
      end else if (scan_accept) begin
         ctr_ff[col_index] <= ctr_in;
      end
   end

endmodule

`default_nettype wire

@@ design/kmds_merge.sv @@
// ----------------------------------------------------------------------------
// kmds_merge: message serializer
// Collects the lane events of one column and sends them lowest row first.
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_merge
   import kmds_pkg::*;
#(
   parameter int COLUMN_COUNT = DEFAULT_COLUMN_COUNT,
   parameter int LANE_COUNT   = DEFAULT_ROW_COUNT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           scan_accept,
   input  wire logic [2:0]     scan_column,
   input  kmds_event_type      lane_event [LANE_COUNT],
   input  wire logic [6:0]     note_base,
   input  wire logic [3:0]     midi_channel,
   input  wire logic [6:0]     note_velocity,
   output logic                busy,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [7:0]          rsp_status_byte,
   output logic [6:0]          rsp_note_number,
   output logic [6:0]          rsp_velocity_out,
   output logic                rsp_last_message
);

   logic [LANE_COUNT-1:0] pending_ff, pending_in;
   logic [LANE_COUNT-1:0] on_ff;
   logic [2:0]            col_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            status_ff;
   logic [6:0]            note_ff;
   logic [6:0]            velocity_ff;
   logic                  last_ff;

   logic [LANE_COUNT-1:0] pick;
   logic [ROW_IDX_W-1:0]  pick_row;
   logic                  send;
   logic [7:0]            row_offset;
   logic [7:0]            note_sum;

   // Lowest pending row wins.
   always_comb begin
      pick     = '0;
      pick_row = '0;
      for (int r = LANE_COUNT - 1; r >= 0; r--) begin
         if (pending_ff[r]) begin
            pick     = '0;
            pick[r]  = 1'b1;
            pick_row = ROW_IDX_W'(r);
         end
      end
   end

   assign send       = (|pending_ff) && (!rsp_valid_ff || !rsp_stall);
   assign row_offset = 8'(pick_row * COLUMN_COUNT);
   assign note_sum   = {1'b0, note_base} + row_offset + {5'b0, col_ff};

   always_comb begin
      pending_in = pending_ff;
      if (scan_accept) begin
         for (int r = 0; r < LANE_COUNT; r++) begin
            pending_in[r] = lane_event[r].hit;
         end
      end else if (send) begin
         pending_in = pending_ff & ~pick;
      end
      rsp_valid_in = send || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_accept) begin
         col_ff <= scan_column;
         for (int r = 0; r < LANE_COUNT; r++) begin
            on_ff[r] <= lane_event[r].is_on;
         end
      end
      if (send) begin
         status_ff   <= ((|(on_ff & pick)) ? NOTE_ON_CODE : NOTE_OFF_CODE)
                        + {4'b0, midi_channel};
         note_ff     <= note_sum[6:0];
         velocity_ff <= note_velocity;
         last_ff     <= ((pending_ff & ~pick) == '0);
      end
   end

   assign busy             = |pending_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status_byte  = status_ff;
   assign rsp_note_number  = note_ff;
   assign rsp_velocity_out = velocity_ff;
   assign rsp_last_message = last_ff;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the key matrix debounce scanner
// Drives scanned columns under random idling and back-pressure, keeps its own
// debounce state per key, and checks every note message field by field.
// ----------------------------------------------------------------------------

module testbench;
   import kmds_pkg::*;

   // Geometry of the block under test; the bench uses the package defaults.
   localparam int COLUMNS     = DEFAULT_COLUMN_COUNT;
   localparam int ROWS        = DEFAULT_ROW_COUNT;
   localparam int KEYS        = COLUMNS * ROWS;
   // Generous bound on the whole run, even with every message stalled to the maximum.
   localparam int CYCLE_LIMIT = 300000;
   // Cycles allowed for a column that raises no message to drain through
   // the block before configuration changes or the run ends.
   localparam int DRAIN_CYCLES = 12;

   // One scanned column as it is handed to the block.
   typedef struct packed {
      logic [2:0] column;
      logic [7:0] rows;
   } scan_item_type;

   // One note message as the block should send it.
   typedef struct packed {
      logic [7:0] status;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       last_flag;
   } note_msg_type;

   // Clock, reset and block ports. Every input has a known value from time 0.
   logic          clock;
   logic          reset            = 1'b1;
   logic          req_valid        = 1'b0;
   logic          req_stall;
   logic [2:0]    req_scan_column  = '0;
   logic [7:0]    req_row_levels   = '0;
   logic          rsp_valid;
   logic          rsp_stall        = 1'b0;
   logic [7:0]    rsp_status_byte;
   logic [6:0]    rsp_note_number;
   logic [6:0]    rsp_velocity_out;
   logic          rsp_last_message;
   logic          csr_valid        = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index        = CSR_DEBOUNCE_COUNT;
   logic [6:0]    csr_data         = '0;

   // Columns waiting to be driven and note messages waiting to arrive.
   scan_item_type scan_queue[$];
   note_msg_type  note_expect_q[$];

   // Shadow copy of the block's configuration and per-key debounce counters.
   logic [6:0]        cfg_debounce  = DEBOUNCE_RESET;
   logic [6:0]        cfg_note_base = NOTE_BASE_RESET;
   logic [3:0]        cfg_channel   = CHANNEL_RESET;
   logic [6:0]        cfg_velocity  = VELOCITY_RESET;
   logic signed [7:0] debounce_ctr [0:KEYS-1];

   // Bookkeeping.
   int            cycle_count     = 0;
   int            mismatch_count  = 0;
   int            register_writes = 0;
   logic          req_taken       = 1'b0;
   int            req_gap_left    = 0;
   int            rsp_hold_left   = 0;
   logic          calm            = 1'b0;
   scan_item_type next_item;

   // Which keys the simulated player is holding down, per column; a 0 bit
   // means pressed, as on the real row lines. The sweep walks the columns in
   // order the way a scanning controller does.
   logic [7:0] finger_state [0:COLUMNS-1];
   logic [2:0] sweep_col = '0;

   key_matrix_debounce_scanner_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scan_column  (req_scan_column),
      .req_row_levels   (req_row_levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_note_number  (rsp_note_number),
      .rsp_velocity_out (rsp_velocity_out),
      .rsp_last_message (rsp_last_message),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Prints one line per mismatch and counts it; the run carries on.
   task report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Works out the messages of one scanned column and advances the debounce
   // counters of its keys. A counter below zero is settling after a press and
   // climbs toward 0; one above 1 is settling after a release and falls
   // toward 1. Only a settled key looks at its line, and only a change of
   // level reloads the counter and raises a message. Rows go lowest first.
   task automatic predict_column(input logic [2:0] column, input logic [7:0] rows);
      logic signed [7:0] load;
      logic signed [7:0] old;
      logic [6:0]        key_index;
      note_msg_type      burst [0:7];
      int                burst_n;
      int                r;
      load    = (cfg_debounce == 7'd0) ? 8'sd1 : $signed({1'b0, cfg_debounce});
      burst_n = 0;
      for (r = 0; r < ROWS; r++) begin
         key_index = 7'(r * COLUMNS + int'(column));
         old       = debounce_ctr[key_index];
         if (old < 0) begin
            debounce_ctr[key_index] = old + 8'sd1;
         end else if (old > 1) begin
            debounce_ctr[key_index] = old - 8'sd1;
         end else if ((old == 0 && rows[r]) || (old == 1 && !rows[r])) begin
            // Settled key whose line shows the other level.
            debounce_ctr[key_index] = rows[r] ? load : -load;
            burst[burst_n].status    = (rows[r] ? NOTE_OFF_CODE : NOTE_ON_CODE)
                                       + {4'd0, cfg_channel};
            burst[burst_n].note      = cfg_note_base + key_index;
            burst[burst_n].velocity  = cfg_velocity;
            burst[burst_n].last_flag = 1'b0;
            burst_n++;
         end
      end
      if (burst_n > 0) begin
         burst[burst_n-1].last_flag = 1'b1;
      end
      for (r = 0; r < burst_n; r++) begin
         note_expect_q.push_back(burst[r]);
      end
   endtask

   // Compares the message on the result port with one expectation.
   task next_expected_check(input note_msg_type want);
      if (rsp_status_byte !== want.status)
         report_mismatch($sformatf("status %h, expected %h (note %0d)",
                                   rsp_status_byte, want.status, want.note));
      if (rsp_note_number !== want.note)
         report_mismatch($sformatf("note %0d, expected %0d", rsp_note_number, want.note));
      if (rsp_velocity_out !== want.velocity)
         report_mismatch($sformatf("velocity %0d, expected %0d (note %0d)",
                                   rsp_velocity_out, want.velocity, want.note));
      if (rsp_last_message !== want.last_flag)
         report_mismatch($sformatf("last flag %b, expected %b (note %0d)",
                                   rsp_last_message, want.last_flag, want.note));
   endtask

   // Handshake monitor: predicts on every accepted column, checks every
   // accepted message against the oldest prediction, and mirrors register
   // writes into the shadow configuration.
   always @(posedge clock) begin
      if (reset) begin
         req_taken     <= 1'b0;
         cfg_debounce  <= DEBOUNCE_RESET;
         cfg_note_base <= NOTE_BASE_RESET;
         cfg_channel   <= CHANNEL_RESET;
         cfg_velocity  <= VELOCITY_RESET;
         for (int k = 0; k < KEYS; k++) begin
            debounce_ctr[k] = 8'sd0;
         end
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_column(req_scan_column, req_row_levels);
         end
         if (rsp_valid && !rsp_stall) begin
            if (note_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected message status %h note %0d",
                                         rsp_status_byte, rsp_note_number));
            end else begin
               next_expected_check(note_expect_q.pop_front());
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE_COUNT: cfg_debounce  <= csr_data;
               CSR_NOTE_BASE:      cfg_note_base <= csr_data;
               CSR_MIDI_CHANNEL:   cfg_channel   <= csr_data[3:0];
               CSR_NOTE_VELOCITY:  cfg_velocity  <= csr_data;
               default: ;
            endcase
            register_writes <= register_writes + 1;
         end
      end
   end

   // Column driver. A new item is presented only once the previous one has
   // been taken, so a stalled item holds still. After an item a gap of random
   // length is sometimes inserted, except in the calm tail.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (scan_queue.size() > 0) begin
            next_item = scan_queue.pop_front();
            req_valid       <= 1'b1;
            req_scan_column <= next_item.column;
            req_row_levels  <= next_item.rows;
            if (!calm && $urandom_range(0, 5) == 0) begin
               req_gap_left <= int'($urandom_range(1, 4));
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Message receiver back-pressure: bursts of stalled cycles at
   // random points, none in the calm tail. The stall does not look at
   // rsp_valid, so it also lands on cycles where the block is busy scanning.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left <= int'($urandom_range(0, 3));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // One register write through the configuration port. The monitor counts
   // completed writes, which tells this task when the handshake happened.
   task automatic write_register(input csr_index_type index, input logic [6:0] value);
      int target;
      target = register_writes + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      while (register_writes != target) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task set_config(input logic [6:0] debounce, input logic [6:0] base,
                   input logic [6:0] channel, input logic [6:0] velocity);
      write_register(CSR_DEBOUNCE_COUNT, debounce);
      write_register(CSR_NOTE_BASE, base);
      write_register(CSR_MIDI_CHANNEL, channel);
      write_register(CSR_NOTE_VELOCITY, velocity);
   endtask

   // Holds the sender back until every queued column has been taken and
   // every predicted message has arrived, then lets a column that raised no
   // message drain out of the block.
   task wait_until_idle;
      while (scan_queue.size() != 0 || req_valid || note_expect_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task queue_scan(input logic [2:0] column, input logic [7:0] rows);
      scan_item_type item;
      item.column = column;
      item.rows   = rows;
      scan_queue.push_back(item);
   endtask

   // Mostly a player pressing and releasing keys on an ordered column sweep,
   // with contact bounce now and then; the rest are arbitrary columns with
   // arbitrary line levels.
   task automatic queue_random_items(input int count);
      scan_item_type item;
      int            n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            item.column = 3'($urandom_range(0, COLUMNS - 1));
            item.rows   = 8'($urandom_range(0, 255));
         end else begin
            item.column = sweep_col;
            sweep_col   = sweep_col + 3'd1;
            if ($urandom_range(0, 2) == 0) begin
               finger_state[item.column] = finger_state[item.column]
                                           ^ (8'd1 << $urandom_range(0, 7));
            end
            item.rows = finger_state[item.column];
            if ($urandom_range(0, 7) == 0) begin
               item.rows = item.rows ^ 8'($urandom_range(0, 255));
            end
         end
         scan_queue.push_back(item);
      end
   endtask

   initial begin
      for (int c = 0; c < COLUMNS; c++) begin
         finger_state[c] = 8'h00;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: every key starts settled as pressed. Releasing
      // the top and bottom rows of column 0 and one key of column 7 checks
      // the reset channel, note base and velocity while locking as few keys
      // as possible behind the long default debounce. A column of all
      // pressed lines raises nothing.
      queue_scan(3'd0, 8'h81);
      queue_scan(3'd7, 8'h02);
      queue_scan(3'd5, 8'h00);
      wait_until_idle();

      // A debounce of zero behaves as one. The highest note base makes note
      // numbers wrap past 127, and channel data with upper bits set must
      // only use its low four bits. Velocity zero.
      set_config(7'd0, 7'h7F, 7'h7A, 7'd0);
      queue_scan(3'd1, 8'hFF);   // full column released
      queue_scan(3'd1, 8'h00);   // full column pressed again
      queue_scan(3'd1, 8'h00);   // presses still settling, nothing sent
      queue_scan(3'd1, 8'hF0);   // upper rows released
      queue_scan(3'd1, 8'h0F);   // presses and releases in one column
      queue_scan(3'd2, 8'h55);
      queue_scan(3'd3, 8'hAA);
      queue_scan(3'd4, 8'h01);
      queue_scan(3'd6, 8'h80);
      queue_scan(3'd7, 8'hFF);   // one key of this column is still settling
      queue_scan(3'd0, 8'h7E);   // two keys of this column are still settling
      queue_scan(3'd6, 8'h7F);
      wait_until_idle();

      // Random phases across the range of every register.
      set_config(7'd1, 7'd0, 7'd0, 7'd127);
      queue_random_items(120);
      wait_until_idle();

      set_config(7'd3, 7'd64, 7'd15, 7'd0);
      queue_random_items(100);
      wait_until_idle();

      set_config(7'd2, 7'h7F, 7'd9, 7'($urandom_range(0, 127)));
      queue_random_items(80);
      wait_until_idle();

      // Longest debounce: any key that changes here stays locked for the
      // rest of the run, so this phase is kept short.
      set_config(7'd127, 7'($urandom_range(0, 64)), 7'($urandom_range(0, 15)),
                 7'($urandom_range(0, 127)));
      queue_random_items(40);
      wait_until_idle();

      // Calm tail: no gaps and no back-pressure, so the block runs at its
      // full rate.
      set_config(7'($urandom_range(1, 5)), 7'($urandom_range(0, 64)),
                 7'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
      calm = 1'b1;
      queue_random_items(80);
      wait_until_idle();

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
